@@ design/assert_macros.svh @@
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is applied.
`define GPC_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that a condition never holds.
`define GPC_NEVER(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ design/gpc_pkg.sv @@
package gpc_pkg;

    localparam int MAX_PADS_DEF     = 4;
    localparam int BUTTON_COUNT_DEF = 14;

    localparam int BTN_W  = 14;
    localparam int AXIS_W = 16;
    localparam int TRIG_W = 8;
    localparam int DZ_W   = 15;

    localparam logic [DZ_W-1:0] DEADZONE_RESET = 15'd6554;
    localparam logic [DZ_W-1:0] FULL_SCALE     = 15'd32767;

    typedef struct packed {
        logic [1:0]               pad;
        logic                     present;
        logic                     connected;
        logic [BTN_W-1:0]         down;
        logic [BTN_W-1:0]         pressed;
        logic [BTN_W-1:0]         released;
        logic signed [AXIS_W-1:0] lx;
        logic signed [AXIS_W-1:0] ly;
        logic signed [AXIS_W-1:0] rx;
        logic signed [AXIS_W-1:0] ry;
        logic [TRIG_W-1:0]        lt;
        logic [TRIG_W-1:0]        rt;
    } job_t;

endpackage

@@ design/gpc_front.sv @@
module gpc_front #(
    parameter int MAX_PADS     = gpc_pkg::MAX_PADS_DEF,
    parameter int BUTTON_COUNT = gpc_pkg::BUTTON_COUNT_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 mode,
    input  logic [1:0]                           pad_index,
    input  logic                                 present,
    input  logic [gpc_pkg::BTN_W-1:0]            buttons,
    input  logic signed [gpc_pkg::AXIS_W-1:0]    raw_left_x,
    input  logic signed [gpc_pkg::AXIS_W-1:0]    raw_left_y,
    input  logic signed [gpc_pkg::AXIS_W-1:0]    raw_right_x,
    input  logic signed [gpc_pkg::AXIS_W-1:0]    raw_right_y,
    input  logic [gpc_pkg::TRIG_W-1:0]           raw_left_trig,
    input  logic [gpc_pkg::TRIG_W-1:0]           raw_right_trig,
    input  logic                                 q_full,
    output logic                                 q_push,
    output gpc_pkg::job_t                        q_data
);

    localparam logic [31:0] BM32 = (BUTTON_COUNT >= 32) ? 32'hFFFF_FFFF
                                 : ((32'd1 << BUTTON_COUNT) - 32'd1);
    localparam logic [gpc_pkg::BTN_W-1:0] BTN_MASK = BM32[gpc_pkg::BTN_W-1:0];

    logic [MAX_PADS-1:0]                 conn_reg;
    logic [gpc_pkg::BTN_W-1:0]           held_reg [MAX_PADS];
    logic [gpc_pkg::BTN_W-1:0]           down_reg [MAX_PADS];
    logic [gpc_pkg::BTN_W-1:0]           up_reg   [MAX_PADS];

    logic                                accept;
    logic                                in_range;
    logic                                cur_conn;
    logic [gpc_pkg::BTN_W-1:0]           cur_held, cur_down, cur_up;
    logic                                conn_next;
    logic [gpc_pkg::BTN_W-1:0]           held_next, down_next, up_next, now;

    assign in_stall = q_full;
    assign accept   = in_valid && !in_stall;
    assign in_range = {30'd0, pad_index} < 32'(MAX_PADS);
    assign now      = buttons & BTN_MASK;

    always_comb
    begin
        cur_conn = 1'b0;
        cur_held = '0;
        cur_down = '0;
        cur_up   = '0;
        for (int i = 0; i < MAX_PADS; i++)
        begin
            if ({30'd0, pad_index} == 32'(i))
            begin
                cur_conn = conn_reg[i];
                cur_held = held_reg[i];
                cur_down = down_reg[i];
                cur_up   = up_reg[i];
            end
        end
        if (present)
        begin
            conn_next = 1'b1;
            down_next = cur_down | (now & ~cur_held);
            up_next   = cur_up | (cur_held & ~now);
            held_next = now;
        end
        else
        begin
            conn_next = 1'b0;
            down_next = cur_down;
            up_next   = cur_conn ? (cur_up | cur_held) : cur_up;
            held_next = cur_conn ? '0 : cur_held;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            conn_reg <= '0;
            for (int i = 0; i < MAX_PADS; i++)
            begin
                held_reg[i] <= '0;
                down_reg[i] <= '0;
                up_reg[i]   <= '0;
            end
        end
        else if (accept)
        begin
            for (int i = 0; i < MAX_PADS; i++)
            begin
                if (mode)
                begin
                    down_reg[i] <= '0;
                    up_reg[i]   <= '0;
                end
                else if ({30'd0, pad_index} == 32'(i))
                begin
                    conn_reg[i] <= conn_next;
                    held_reg[i] <= held_next;
                    down_reg[i] <= down_next;
                    up_reg[i]   <= up_next;
                end
            end
        end
    end

    assign q_push = accept && !mode && in_range;

    always_comb
    begin
        q_data.pad       = pad_index;
        q_data.present   = present;
        q_data.connected = conn_next;
        q_data.down      = held_next;
        q_data.pressed   = down_next;
        q_data.released  = up_next;
        q_data.lx        = raw_left_x;
        q_data.ly        = raw_left_y;
        q_data.rx        = raw_right_x;
        q_data.ry        = raw_right_y;
        q_data.lt        = present ? raw_left_trig : '0;
        q_data.rt        = present ? raw_right_trig : '0;
    end

endmodule

@@ design/gpc_queue.sv @@
module gpc_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  gpc_pkg::job_t push_data,
    input  logic          pop,
    output gpc_pkg::job_t pop_data,
    output logic          full,
    output logic          empty
);

    gpc_pkg::job_t mem_reg [2];
    logic          wr_ptr_reg, rd_ptr_reg;
    logic [1:0]    count_reg;

    assign full     = count_reg == 2'd2;
    assign empty    = count_reg == 2'd0;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

@@ design/gpc_back.sv @@
module gpc_back (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [gpc_pkg::DZ_W-1:0]           deadzone,
    input  logic                               q_empty,
    input  gpc_pkg::job_t                      q_data,
    output logic                               q_pop,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [1:0]                         out_pad,
    output logic                               is_connected,
    output logic [gpc_pkg::BTN_W-1:0]          down_mask,
    output logic [gpc_pkg::BTN_W-1:0]          pressed_mask,
    output logic [gpc_pkg::BTN_W-1:0]          released_mask,
    output logic signed [gpc_pkg::AXIS_W-1:0]  left_x,
    output logic signed [gpc_pkg::AXIS_W-1:0]  left_y,
    output logic signed [gpc_pkg::AXIS_W-1:0]  right_x,
    output logic signed [gpc_pkg::AXIS_W-1:0]  right_y,
    output logic [gpc_pkg::TRIG_W-1:0]         left_trig,
    output logic [gpc_pkg::TRIG_W-1:0]         right_trig
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_LOAD = 4'd1;
    localparam logic [3:0] S_M1   = 4'd2;
    localparam logic [3:0] S_M2   = 4'd3;
    localparam logic [3:0] S_M3   = 4'd4;
    localparam logic [3:0] S_CHK  = 4'd5;
    localparam logic [3:0] S_SQRT = 4'd6;
    localparam logic [3:0] S_MAG  = 4'd7;
    localparam logic [3:0] S_NUM  = 4'd8;
    localparam logic [3:0] S_DIV  = 4'd9;
    localparam logic [3:0] S_POST = 4'd10;
    localparam logic [3:0] S_NEXT = 4'd11;
    localparam logic [3:0] S_EMIT = 4'd12;

    localparam logic [1:0] PH_SCALE = 2'd0;
    localparam logic [1:0] PH_AX    = 2'd1;
    localparam logic [1:0] PH_AY    = 2'd2;

    logic [3:0]          state_reg;
    gpc_pkg::job_t       job_reg;
    logic                sel_reg;
    logic [14:0]         ax_reg, ay_reg;
    logic                negx_reg, negy_reg;
    logic [30:0]         m2_reg;
    logic [29:0]         dd_reg;
    logic [31:0]         rem_reg, res_reg, bit_reg;
    logic [4:0]          cnt_reg;
    logic [15:0]         mag_reg;
    logic [1:0]          phase_reg;
    logic [14:0]         scaled_reg;
    logic [31:0]         dvd_reg;
    logic [15:0]         dvs_reg, drem_reg;
    logic signed [15:0]  ox_reg, oy_reg;
    logic signed [15:0]  lx_res_reg, ly_res_reg, rx_res_reg, ry_res_reg;
    logic                out_valid_reg;

    logic signed [15:0]  x_sel, y_sel, x_cl, y_cl;
    logic [14:0]         ax, ay;
    logic [31:0]         trial;
    logic [16:0]         r17;
    logic                ge;
    logic [15:0]         drem_next;
    logic signed [15:0]  q_s;
    logic                out_free;

    assign out_free = !out_valid_reg || !out_stall;
    assign q_pop    = (state_reg == S_IDLE) && !q_empty;

    always_comb
    begin
        x_sel = sel_reg ? job_reg.rx : job_reg.lx;
        y_sel = sel_reg ? job_reg.ry : job_reg.ly;
        x_cl  = (x_sel == 16'sh8000) ? 16'sh8001 : x_sel;
        y_cl  = (y_sel == 16'sh8000) ? 16'sh8001 : y_sel;
        ax    = x_cl[15] ? 15'(-x_cl) : x_cl[14:0];
        ay    = y_cl[15] ? 15'(-y_cl) : y_cl[14:0];
        trial = res_reg + bit_reg;
        r17   = {drem_reg, dvd_reg[31]};
        ge    = r17 >= {1'b0, dvs_reg};
        drem_next = ge ? 16'(r17 - {1'b0, dvs_reg}) : r17[15:0];
        q_s   = signed'({1'b0, dvd_reg[14:0]});
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                job_reg    <= q_data;
                lx_res_reg <= '0;
                ly_res_reg <= '0;
                rx_res_reg <= '0;
                ry_res_reg <= '0;
            end
            S_LOAD:
            begin
                ax_reg   <= ax;
                ay_reg   <= ay;
                negx_reg <= x_cl[15];
                negy_reg <= y_cl[15];
                ox_reg   <= '0;
                oy_reg   <= '0;
            end
            S_M1: m2_reg <= 31'(ax_reg * ax_reg);
            S_M2: m2_reg <= m2_reg + 31'(ay_reg * ay_reg);
            S_M3: dd_reg <= 30'(deadzone * deadzone);
            S_CHK:
            begin
                rem_reg <= {1'b0, m2_reg};
                res_reg <= '0;
                bit_reg <= 32'h4000_0000;
            end
            S_SQRT:
            begin
                if (rem_reg >= trial)
                begin
                    rem_reg <= rem_reg - trial;
                    res_reg <= (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_reg <= res_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
            S_MAG:
            begin
                mag_reg <= res_reg[15:0];
                scaled_reg <= gpc_pkg::FULL_SCALE;
            end
            S_NUM:
            begin
                drem_reg <= '0;
                priority case (phase_reg)
                    PH_SCALE:
                    begin
                        dvd_reg <= 32'((mag_reg - {1'b0, deadzone}) * gpc_pkg::FULL_SCALE);
                        dvs_reg <= {1'b0, gpc_pkg::FULL_SCALE} - {1'b0, deadzone};
                    end
                    PH_AX:
                    begin
                        dvd_reg <= 32'(ax_reg * scaled_reg);
                        dvs_reg <= mag_reg;
                    end
                    default:
                    begin
                        dvd_reg <= 32'(ay_reg * scaled_reg);
                        dvs_reg <= mag_reg;
                    end
                endcase
            end
            S_DIV:
            begin
                drem_reg <= drem_next;
                dvd_reg  <= {dvd_reg[30:0], ge};
            end
            S_POST:
            begin
                priority case (phase_reg)
                    PH_SCALE: scaled_reg <= (dvd_reg > 32'd32767) ? gpc_pkg::FULL_SCALE
                                                                  : dvd_reg[14:0];
                    PH_AX:    ox_reg <= negx_reg ? -q_s : q_s;
                    default:  oy_reg <= negy_reg ? -q_s : q_s;
                endcase
            end
            S_NEXT:
            begin
                if (sel_reg)
                begin
                    rx_res_reg <= ox_reg;
                    ry_res_reg <= oy_reg;
                end
                else
                begin
                    lx_res_reg <= ox_reg;
                    ly_res_reg <= oy_reg;
                end
            end
            default:
            begin
            end
        endcase
        if (state_reg == S_EMIT && out_free)
        begin
            out_pad       <= job_reg.pad;
            is_connected  <= job_reg.connected;
            down_mask     <= job_reg.down;
            pressed_mask  <= job_reg.pressed;
            released_mask <= job_reg.released;
            left_x        <= lx_res_reg;
            left_y        <= ly_res_reg;
            right_x       <= rx_res_reg;
            right_y       <= ry_res_reg;
            left_trig     <= job_reg.lt;
            right_trig    <= job_reg.rt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sel_reg       <= 1'b0;
            cnt_reg       <= '0;
            phase_reg     <= PH_SCALE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    sel_reg <= 1'b0;
                    if (!q_empty)
                    begin
                        state_reg <= q_data.present ? S_LOAD : S_EMIT;
                    end
                end
                S_LOAD: state_reg <= S_M1;
                S_M1:   state_reg <= S_M2;
                S_M2:   state_reg <= S_M3;
                S_M3:   state_reg <= S_CHK;
                S_CHK:
                begin
                    cnt_reg   <= '0;
                    // inside the deadzone: outputs stay zero
                    state_reg <= ({1'b0, dd_reg} > m2_reg) ? S_NEXT : S_SQRT;
                end
                S_SQRT:
                begin
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd15)
                    begin
                        state_reg <= S_MAG;
                    end
                end
                S_MAG:
                begin
                    phase_reg <= (deadzone == gpc_pkg::FULL_SCALE) ? PH_AX : PH_SCALE;
                    state_reg <= (res_reg[15:0] == 16'd0) ? S_NEXT : S_NUM;
                end
                S_NUM:
                begin
                    cnt_reg   <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd31)
                    begin
                        state_reg <= S_POST;
                    end
                end
                S_POST:
                begin
                    priority case (phase_reg)
                        PH_SCALE:
                        begin
                            phase_reg <= PH_AX;
                            state_reg <= S_NUM;
                        end
                        PH_AX:
                        begin
                            phase_reg <= PH_AY;
                            state_reg <= S_NUM;
                        end
                        default: state_reg <= S_NEXT;
                    endcase
                end
                S_NEXT:
                begin
                    sel_reg   <= 1'b1;
                    state_reg <= sel_reg ? S_EMIT : S_LOAD;
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid = out_valid_reg;

endmodule

@@ design/gamepad_report_conditioner.sv @@
// channel   dir  handshake           payload
// in        in   in_valid/in_stall   mode, pad_index, present, buttons, raw sticks, triggers
// out       out  out_valid/out_stall out_pad, masks, conditioned sticks, triggers
// cfg       in   cfg_valid/cfg_ready cfg_data = stick_deadzone
//
// Button state is updated as an item is taken; a two-entry queue feeds the stick unit.
// A present report goes through the stick unit: per stick a 16-step
// square root and up to three 32-step restoring divides through one shared divider
// (a stick inside the deadzone skips both).
// An absent report skips the stick math. Begin-frame items give no result.
// Reset clears all pad state and sets the deadzone to 6554.
// in_stall is high while the queue is full; out_stall holds the result register.
module gamepad_report_conditioner #(
    parameter int MAX_PADS     = gpc_pkg::MAX_PADS_DEF,
    parameter int BUTTON_COUNT = gpc_pkg::BUTTON_COUNT_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [gpc_pkg::DZ_W-1:0]           cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               mode,
    input  logic [1:0]                         pad_index,
    input  logic                               present,
    input  logic [gpc_pkg::BTN_W-1:0]          buttons,
    input  logic signed [gpc_pkg::AXIS_W-1:0]  raw_left_x,
    input  logic signed [gpc_pkg::AXIS_W-1:0]  raw_left_y,
    input  logic signed [gpc_pkg::AXIS_W-1:0]  raw_right_x,
    input  logic signed [gpc_pkg::AXIS_W-1:0]  raw_right_y,
    input  logic [gpc_pkg::TRIG_W-1:0]         raw_left_trig,
    input  logic [gpc_pkg::TRIG_W-1:0]         raw_right_trig,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [1:0]                         out_pad,
    output logic                               is_connected,
    output logic [gpc_pkg::BTN_W-1:0]          down_mask,
    output logic [gpc_pkg::BTN_W-1:0]          pressed_mask,
    output logic [gpc_pkg::BTN_W-1:0]          released_mask,
    output logic signed [gpc_pkg::AXIS_W-1:0]  left_x,
    output logic signed [gpc_pkg::AXIS_W-1:0]  left_y,
    output logic signed [gpc_pkg::AXIS_W-1:0]  right_x,
    output logic signed [gpc_pkg::AXIS_W-1:0]  right_y,
    output logic [gpc_pkg::TRIG_W-1:0]         left_trig,
    output logic [gpc_pkg::TRIG_W-1:0]         right_trig
);

    logic [gpc_pkg::DZ_W-1:0] deadzone_reg;
    logic                     q_full, q_empty, q_push, q_pop;
    gpc_pkg::job_t            push_data, pop_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deadzone_reg <= gpc_pkg::DEADZONE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            deadzone_reg <= cfg_data;
        end
    end

    gpc_front #(
        .MAX_PADS     (MAX_PADS),
        .BUTTON_COUNT (BUTTON_COUNT)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .mode           (mode),
        .pad_index      (pad_index),
        .present        (present),
        .buttons        (buttons),
        .raw_left_x     (raw_left_x),
        .raw_left_y     (raw_left_y),
        .raw_right_x    (raw_right_x),
        .raw_right_y    (raw_right_y),
        .raw_left_trig  (raw_left_trig),
        .raw_right_trig (raw_right_trig),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_data         (push_data)
    );

    gpc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_data),
        .pop       (q_pop),
        .pop_data  (pop_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    gpc_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .deadzone      (deadzone_reg),
        .q_empty       (q_empty),
        .q_data        (pop_data),
        .q_pop         (q_pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_pad       (out_pad),
        .is_connected  (is_connected),
        .down_mask     (down_mask),
        .pressed_mask  (pressed_mask),
        .released_mask (released_mask),
        .left_x        (left_x),
        .left_y        (left_y),
        .right_x       (right_x),
        .right_y       (right_y),
        .left_trig     (left_trig),
        .right_trig    (right_trig)
    );

endmodule

@@ design/gpc_checker.sv @@
`include "assert_macros.svh"

module gpc_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               out_valid,
    input logic                               out_stall,
    input logic                               is_connected,
    input logic [gpc_pkg::BTN_W-1:0]          down_mask,
    input logic signed [gpc_pkg::AXIS_W-1:0]  left_x,
    input logic signed [gpc_pkg::AXIS_W-1:0]  right_x,
    input logic [gpc_pkg::TRIG_W-1:0]         left_trig,
    input logic [gpc_pkg::TRIG_W-1:0]         right_trig
);

    `GPC_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(left_x), "result dropped under stall")
    `GPC_ASSERT(a_absent_zero, out_valid && !is_connected |-> left_x == 16'sd0 && right_x == 16'sd0 && left_trig == 8'd0 && right_trig == 8'd0, "absent pad has nonzero axes")
    `GPC_ASSERT(a_absent_held, out_valid && !is_connected |-> down_mask == '0, "absent pad still holds buttons")
    `GPC_NEVER(a_no_min, out_valid && (left_x == 16'sh8000 || right_x == 16'sh8000), "stick output out of range")

endmodule

bind gamepad_report_conditioner gpc_checker u_gpc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .is_connected (is_connected),
    .down_mask    (down_mask),
    .left_x       (left_x),
    .right_x      (right_x),
    .left_trig    (left_trig),
    .right_trig   (right_trig)
);

@@ bench/testbench.sv @@
module testbench;

    localparam logic MODE_REPORT = 1'b0;
    localparam logic MODE_FRAME  = 1'b1;
    localparam int   NUM_SLOTS   = gpc_pkg::MAX_PADS_DEF;
    localparam int   STICK_ONE   = 32767;
    localparam int   SETTLE      = 400;
    localparam int   WATCHDOG    = 6000;

    typedef struct {
        logic                              mode;
        logic [1:0]                        pad;
        logic                              present;
        logic [gpc_pkg::BTN_W-1:0]         buttons;
        logic signed [gpc_pkg::AXIS_W-1:0] lx, ly, rx, ry;
        logic [gpc_pkg::TRIG_W-1:0]        lt, rt;
    } report_t;

    typedef struct {
        logic [1:0]                        pad;
        logic                              connected;
        logic [gpc_pkg::BTN_W-1:0]         down, pressed, released;
        logic signed [gpc_pkg::AXIS_W-1:0] lx, ly, rx, ry;
        logic [gpc_pkg::TRIG_W-1:0]        lt, rt;
    } pad_state_t;

    class pad_scoreboard;
        pad_state_t                pending[$];
        int                        errors;
        int                        reports, frames, results;
        logic [gpc_pkg::DZ_W-1:0]  deadzone;
        logic                      connected[NUM_SLOTS];
        logic [gpc_pkg::BTN_W-1:0] held[NUM_SLOTS], rose[NUM_SLOTS], fell[NUM_SLOTS];

        function new();
            errors = 0;
            reports = 0;
            frames = 0;
            results = 0;
            deadzone = gpc_pkg::DEADZONE_RESET;
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                connected[i] = 1'b0;
                held[i] = '0;
                rose[i] = '0;
                fell[i] = '0;
            end
        endfunction

        function int unsigned root_floor(int unsigned v);
            int unsigned acc;
            int unsigned b;
            acc = 0;
            b = 32'h4000_0000;
            while (b > v)
                b = b >> 2;
            while (b != 0)
            begin
                if (v >= acc + b)
                begin
                    v = v - (acc + b);
                    acc = (acc >> 1) + b;
                end
                else
                    acc = acc >> 1;
                b = b >> 2;
            end
            return acc;
        endfunction

        function int clamp_axis(logic signed [gpc_pkg::AXIS_W-1:0] raw);
            int v;
            v = int'(raw);
            return (v < -STICK_ONE) ? -STICK_ONE : v;
        endfunction

        function int shrink(int v, longint scaled, longint mag);
            longint a;
            longint r;
            a = longint'((v < 0) ? -v : v);
            r = (a * scaled) / mag;
            return (v < 0) ? -int'(r) : int'(r);
        endfunction

        function void condition_stick(logic signed [gpc_pkg::AXIS_W-1:0] rawx,
                                      logic signed [gpc_pkg::AXIS_W-1:0] rawy,
                                      output logic signed [gpc_pkg::AXIS_W-1:0] ox,
                                      output logic signed [gpc_pkg::AXIS_W-1:0] oy);
            int x, y;
            int unsigned m2, d, mag;
            longint scaled;
            x = clamp_axis(rawx);
            y = clamp_axis(rawy);
            d = {17'd0, deadzone};
            m2 = unsigned'(x * x + y * y);
            ox = '0;
            oy = '0;
            if (m2 < d * d)
                return;
            mag = root_floor(m2);
            if (mag == 0)
                return;
            if (d >= STICK_ONE)
                scaled = longint'(STICK_ONE);
            else
            begin
                scaled = (longint'(mag - d) * STICK_ONE) / longint'(STICK_ONE - d);
                if (scaled > STICK_ONE)
                    scaled = longint'(STICK_ONE);
            end
            ox = 16'(shrink(x, scaled, longint'(mag)));
            oy = 16'(shrink(y, scaled, longint'(mag)));
        endfunction

        function void note_input(report_t it);
            pad_state_t r;
            int p;
            if (it.mode == MODE_FRAME)
            begin
                frames++;
                for (int i = 0; i < NUM_SLOTS; i++)
                begin
                    rose[i] = '0;
                    fell[i] = '0;
                end
                return;
            end
            reports++;
            p = int'(it.pad);
            r.lx = '0; r.ly = '0; r.rx = '0; r.ry = '0;
            r.lt = '0; r.rt = '0;
            if (!it.present)
            begin
                if (connected[p])
                begin
                    fell[p] |= held[p];
                    held[p] = '0;
                end
                connected[p] = 1'b0;
            end
            else
            begin
                connected[p] = 1'b1;
                rose[p] |= it.buttons & ~held[p];
                fell[p] |= held[p] & ~it.buttons;
                held[p] = it.buttons;
                condition_stick(it.lx, it.ly, r.lx, r.ly);
                condition_stick(it.rx, it.ry, r.rx, r.ry);
                r.lt = it.lt;
                r.rt = it.rt;
            end
            r.pad = it.pad;
            r.connected = connected[p];
            r.down = held[p];
            r.pressed = rose[p];
            r.released = fell[p];
            pending.push_back(r);
        endfunction

        function void check_result(pad_state_t got);
            pad_state_t w;
            results++;
            if (pending.size() == 0)
            begin
                $error("result for pad %0d with no report waiting", got.pad);
                errors++;
                return;
            end
            w = pending.pop_front();
            if (got.pad !== w.pad)
            begin $error("out_pad exp %0d got %0d", w.pad, got.pad); errors++; end
            if (got.connected !== w.connected)
            begin $error("is_connected exp %0d got %0d", w.connected, got.connected); errors++; end
            if (got.down !== w.down)
            begin $error("down_mask exp %h got %h", w.down, got.down); errors++; end
            if (got.pressed !== w.pressed)
            begin $error("pressed_mask exp %h got %h", w.pressed, got.pressed); errors++; end
            if (got.released !== w.released)
            begin $error("released_mask exp %h got %h", w.released, got.released); errors++; end
            if (got.lx !== w.lx)
            begin $error("left_x exp %0d got %0d", w.lx, got.lx); errors++; end
            if (got.ly !== w.ly)
            begin $error("left_y exp %0d got %0d", w.ly, got.ly); errors++; end
            if (got.rx !== w.rx)
            begin $error("right_x exp %0d got %0d", w.rx, got.rx); errors++; end
            if (got.ry !== w.ry)
            begin $error("right_y exp %0d got %0d", w.ry, got.ry); errors++; end
            if (got.lt !== w.lt)
            begin $error("left_trig exp %0d got %0d", w.lt, got.lt); errors++; end
            if (got.rt !== w.rt)
            begin $error("right_trig exp %0d got %0d", w.rt, got.rt); errors++; end
        endfunction
    endclass

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              cfg_valid = 1'b0;
    logic                              cfg_ready;
    logic [gpc_pkg::DZ_W-1:0]          cfg_data = '0;
    logic                              in_valid = 1'b0;
    logic                              in_stall;
    logic                              mode = 1'b0;
    logic [1:0]                        pad_index = '0;
    logic                              present = 1'b0;
    logic [gpc_pkg::BTN_W-1:0]         buttons = '0;
    logic signed [gpc_pkg::AXIS_W-1:0] raw_left_x = '0, raw_left_y = '0;
    logic signed [gpc_pkg::AXIS_W-1:0] raw_right_x = '0, raw_right_y = '0;
    logic [gpc_pkg::TRIG_W-1:0]        raw_left_trig = '0, raw_right_trig = '0;
    logic                              out_valid;
    logic                              out_stall = 1'b0;
    logic [1:0]                        out_pad;
    logic                              is_connected;
    logic [gpc_pkg::BTN_W-1:0]         down_mask, pressed_mask, released_mask;
    logic signed [gpc_pkg::AXIS_W-1:0] left_x, left_y, right_x, right_y;
    logic [gpc_pkg::TRIG_W-1:0]        left_trig, right_trig;

    pad_scoreboard sb = new();
    int  sender_idle_pct = 0;
    int  receiver_stall_pct = 0;
    int  quiet_cycles = 0;
    logic [gpc_pkg::BTN_W-1:0] last_buttons[NUM_SLOTS];

    gamepad_report_conditioner i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .mode           (mode),
        .pad_index      (pad_index),
        .present        (present),
        .buttons        (buttons),
        .raw_left_x     (raw_left_x),
        .raw_left_y     (raw_left_y),
        .raw_right_x    (raw_right_x),
        .raw_right_y    (raw_right_y),
        .raw_left_trig  (raw_left_trig),
        .raw_right_trig (raw_right_trig),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_pad        (out_pad),
        .is_connected   (is_connected),
        .down_mask      (down_mask),
        .pressed_mask   (pressed_mask),
        .released_mask  (released_mask),
        .left_x         (left_x),
        .left_y         (left_y),
        .right_x        (right_x),
        .right_y        (right_y),
        .left_trig      (left_trig),
        .right_trig     (right_trig)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
        out_stall <= rst_n && ($urandom_range(99) < receiver_stall_pct);

    // handshake signals only change at posedge, so the negedge view holds at the next edge
    always @(negedge clk)
    begin
        pad_state_t got;
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG)
            begin
                $display("Some tests failed");
                $finish;
            end
            if (out_valid && !out_stall)
            begin
                got.pad = out_pad;
                got.connected = is_connected;
                got.down = down_mask;
                got.pressed = pressed_mask;
                got.released = released_mask;
                got.lx = left_x;
                got.ly = left_y;
                got.rx = right_x;
                got.ry = right_y;
                got.lt = left_trig;
                got.rt = right_trig;
                sb.check_result(got);
            end
        end
    end

    // entered and left at a rising edge
    task automatic send_item(report_t it);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        mode <= it.mode;
        pad_index <= it.pad;
        present <= it.present;
        buttons <= it.buttons;
        raw_left_x <= it.lx;
        raw_left_y <= it.ly;
        raw_right_x <= it.rx;
        raw_right_y <= it.ry;
        raw_left_trig <= it.lt;
        raw_right_trig <= it.rt;
        @(negedge clk);
        while (in_stall)
            @(negedge clk);
        @(posedge clk);
        sb.note_input(it);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_deadzone(logic [gpc_pkg::DZ_W-1:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(negedge clk);
        while (!cfg_ready)
            @(negedge clk);
        @(posedge clk);
        cfg_valid <= 1'b0;
        sb.deadzone = v;
    endtask

    function automatic logic signed [gpc_pkg::AXIS_W-1:0] pick_axis();
        case ($urandom_range(9))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return '0;
            3: return 16'($urandom_range(2000) - 1000);
            4, 5: return 16'($urandom_range(16000) - 8000);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic report_t pick_report();
        report_t it;
        int p;
        it.mode = ($urandom_range(99) < 7) ? MODE_FRAME : MODE_REPORT;
        it.pad = 2'($urandom_range(3));
        p = int'(it.pad);
        it.present = ($urandom_range(99) < 85);
        // mostly flip a few bits of the last levels so edges build up across frames
        if ($urandom_range(3) == 0)
            it.buttons = 14'($urandom);
        else
            it.buttons = last_buttons[p] ^ (14'd1 << $urandom_range(13))
                         ^ (($urandom_range(1) == 1) ? (14'd1 << $urandom_range(13)) : 14'd0);
        if (it.present && it.mode == MODE_REPORT)
            last_buttons[p] = it.buttons;
        it.lx = pick_axis();
        it.ly = pick_axis();
        it.rx = pick_axis();
        it.ry = pick_axis();
        it.lt = 8'($urandom);
        it.rt = 8'($urandom);
        return it;
    endfunction

    function automatic report_t make_report(logic [1:0] p, logic pr,
                                            logic [gpc_pkg::BTN_W-1:0] b,
                                            int lx, int ly, int rx, int ry, int lt, int rt);
        report_t it;
        it.mode = MODE_REPORT;
        it.pad = p;
        it.present = pr;
        it.buttons = b;
        it.lx = 16'(lx); it.ly = 16'(ly); it.rx = 16'(rx); it.ry = 16'(ry);
        it.lt = 8'(lt); it.rt = 8'(rt);
        return it;
    endfunction

    task automatic directed_part();
        report_t frame;
        frame = make_report(0, 1, 14'h3fff, 0, 0, 0, 0, 0, 0);
        frame.mode = MODE_FRAME;
        // absent report on a pad never connected
        send_item(make_report(2, 0, 14'h1234, 100, 100, 100, 100, 9, 9));
        send_item(make_report(0, 1, 14'h3fff, -32768, -32768, 32767, 32767, 255, 255));
        send_item(make_report(0, 1, 14'h0000, 32767, 0, 0, -32768, 0, 0));
        send_item(make_report(1, 1, 14'h2aaa, 6554, 0, 6553, 0, 128, 1));
        send_item(make_report(1, 1, 14'h1555, 4634, 4634, -4634, -4635, 1, 128));
        send_item(frame);
        send_item(make_report(0, 1, 14'h0f0f, 0, 0, 0, 0, 17, 34));
        send_item(make_report(3, 1, 14'h3fff, 20000, -20000, -1, 1, 200, 50));
        // held buttons move to released when the pad drops out
        send_item(make_report(3, 0, 14'h0000, 5000, 5000, 5000, 5000, 77, 77));
        send_item(make_report(3, 0, 14'h3fff, 0, 0, 0, 0, 0, 0));
        send_item(frame);
        send_item(make_report(3, 1, 14'h0001, -32768, 32767, 32767, -32768, 255, 0));
        write_deadzone(0);
        send_item(make_report(0, 1, 14'h0000, 0, 0, 1, 0, 0, 255));
        send_item(make_report(2, 1, 14'h2000, -1, -1, 32767, 32767, 3, 4));
        write_deadzone(32766);
        send_item(make_report(2, 1, 14'h0000, 32767, 0, 32767, 32767, 5, 6));
        send_item(make_report(1, 1, 14'h3fff, 32766, 0, -32768, 0, 7, 8));
        send_item(make_report(1, 1, 14'h3fff, 23170, 23170, 0, 32765, 9, 10));
        write_deadzone(1);
        send_item(make_report(0, 1, 14'h0001, 1, 0, 0, 1, 11, 12));
        send_item(make_report(0, 1, 14'h0002, 0, 0, -1, 0, 13, 14));
    endtask

    initial
    begin
        logic [gpc_pkg::DZ_W-1:0] zones[6];
        zones = '{15'd6554, 15'd0, 15'd32766, 15'd16384, 15'd1, 15'd0};
        for (int i = 0; i < NUM_SLOTS; i++)
            last_buttons[i] = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        directed_part();
        for (int s = 0; s < 6; s++)
        begin
            write_deadzone((s == 5) ? 15'($urandom_range(32766)) : zones[s]);
            for (int k = 0; k < 290; k++)
            begin
                if (k < 100)
                begin
                    sender_idle_pct = 28;
                    receiver_stall_pct = 62;
                end
                else if (k < 200)
                begin
                    sender_idle_pct = 62;
                    receiver_stall_pct = 28;
                end
                else
                begin
                    sender_idle_pct = 0;
                    receiver_stall_pct = 0;
                end
                // hold off until the block has caught up, once per setting
                if (k == 150)
                begin
                    in_valid <= 1'b0;
                    do
                        @(posedge clk);
                    while (sb.pending.size() != 0);
                end
                send_item(pick_report());
            end
        end
        receiver_stall_pct = 0;
        drain();
        $display("Covered %0d pad reports and %0d frame starts, %0d results checked,",
                 sb.reports, sb.frames, sb.results);
        $display("over six deadzone settings including zero and near full scale.");
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
